// ===== rtl/core/sscr_pkg.sv =====
// ----------------------------------------------------------------------------
// sscr_pkg
// Shared types and constants for the screen cell renderer: image geometry,
// stream payload layout and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package sscr_pkg;

   // Screen image geometry
   localparam int unsigned ScreenBytes = 6912;
   localparam int unsigned AddrW       = 13;
   localparam logic [AddrW-1:0] ScreenLimit = AddrW'(ScreenBytes);
   // Attribute area starts at 0x1800: the top two address bits set
   localparam logic [1:0] AttrBaseTop  = 2'b11;
   localparam logic [1:0] ThirdBeyond  = 2'd3;

   // Attribute byte layout
   localparam int unsigned BrightBit = 6;

   // Field widths
   localparam int unsigned XOffW   = 9;
   localparam int unsigned YOffW   = 8;
   localparam int unsigned ClipWW  = 10;
   localparam int unsigned ClipHW  = 9;
   localparam int unsigned PixXW   = 10;
   localparam int unsigned PixYW   = 9;
   localparam int unsigned ColW    = 32;
   localparam int unsigned MaskW   = 8;

   // Stream payload widths
   localparam int unsigned ReqDataW = 40;
   localparam int unsigned RspDataW = 64;

   // Configuration port
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 10;
   localparam logic [CsrIdxW-1:0] CSR_X_OFFSET    = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_Y_OFFSET    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CLIP_WIDTH  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_CLIP_HEIGHT = 2'd3;

   // Register reset values
   localparam logic [XOffW-1:0]  XOffReset  = 9'd77;
   localparam logic [YOffW-1:0]  YOffReset  = 8'd52;
   localparam logic [ClipWW-1:0] ClipWReset = 10'd312;
   localparam logic [ClipHW-1:0] ClipHReset = 9'd230;

   // Input item kind carried on tuser
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   typedef struct packed {
      logic write_byte;    // store the accepted byte into the image
      logic start_render;  // capture render fields, read bitmap byte
      logic read_attr;     // latch bitmap byte, read attribute byte
      logic load_out;      // form the result into the output register
   } sscr_cmd_type;

   typedef struct packed {
      logic out_free;      // output register can take a result this cycle
   } sscr_status_type;

endpackage

// ===== rtl/core/spectrum_screen_cell_render.sv =====
// A render item reads its bitmap byte, then its attribute byte, through the
// single memory port, then loads its result into the output register once
// it is free; no new item is taken until then, while a write item leaves
// the block ready at once. Reset clears the sequencer, output valid and
// settings; the screen image is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// spectrum_screen_cell_render
// Renders one eight-pixel run of a Spectrum style screen image into 4-bit
// colour indices with screen coordinates and a clip visibility mask.
// ----------------------------------------------------------------------------
module spectrum_screen_cell_render (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [12:0] byte_address, [20:13] byte_value, [22:21] third,
   // [25:23] char_row, [28:26] pixel_line, [33:29] column, [39:34] zero
   input  logic [sscr_pkg::ReqDataW-1:0] req_tdata,
   // [0] mode
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [9:0] pixel_x, [18:10] pixel_y, [50:19] colours,
   // [58:51] visible_mask, [63:59] zero
   output logic [sscr_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [sscr_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sscr_pkg::CsrDataW-1:0] csr_wdata
);
   import sscr_pkg::*;

   sscr_cmd_type    cmd;
   sscr_status_type status;

   sscr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   sscr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/sscr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sscr_ctrl
// Sequencer for the screen cell renderer: accepts items and steps a render
// through its bitmap read, attribute read and result formation.
// ----------------------------------------------------------------------------
module sscr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_mode,
   input  sscr_pkg::sscr_status_type status,
   output sscr_pkg::sscr_cmd_type   cmd
);
   import sscr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ATTR = 2'd1;
   localparam logic [1:0] ST_FORM = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_RENDER) begin
                  cmd.start_render = 1'b1;
                  state_in         = ST_ATTR;
               end else begin
                  cmd.write_byte = 1'b1;
               end
            end
         end
         ST_ATTR: begin
            cmd.read_attr = 1'b1;
            state_in      = ST_FORM;
         end
         ST_FORM: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/sscr_dp.sv =====
// ----------------------------------------------------------------------------
// sscr_dp
// Datapath for the screen cell renderer: screen image memory, settings
// registers, colour decode, coordinates, clip mask and output register.
// ----------------------------------------------------------------------------
module sscr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sscr_pkg::sscr_cmd_type              cmd,
   output sscr_pkg::sscr_status_type           status,
   input  logic [sscr_pkg::ReqDataW-1:0]       req_tdata,
   input  logic                                csr_wr_en,
   input  logic [sscr_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [sscr_pkg::CsrDataW-1:0]       csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sscr_pkg::RspDataW-1:0]       rsp_tdata
);
   import sscr_pkg::*;

   // request fields
   logic [AddrW-1:0] in_addr;
   logic [7:0]       in_value;
   logic [1:0]       in_third;
   logic [2:0]       in_row;
   logic [2:0]       in_line;
   logic [4:0]       in_col;

   assign in_addr  = req_tdata[12:0];
   assign in_value = req_tdata[20:13];
   assign in_third = req_tdata[22:21];
   assign in_row   = req_tdata[25:23];
   assign in_line  = req_tdata[28:26];
   assign in_col   = req_tdata[33:29];

   // settings
   logic [XOffW-1:0]  x_offset_ff;
   logic [YOffW-1:0]  y_offset_ff;
   logic [ClipWW-1:0] clip_width_ff;
   logic [ClipHW-1:0] clip_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff    <= XOffReset;
         y_offset_ff    <= YOffReset;
         clip_width_ff  <= ClipWReset;
         clip_height_ff <= ClipHReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_X_OFFSET:    x_offset_ff    <= csr_wdata[XOffW-1:0];
            CSR_Y_OFFSET:    y_offset_ff    <= csr_wdata[YOffW-1:0];
            CSR_CLIP_WIDTH:  clip_width_ff  <= csr_wdata[ClipWW-1:0];
            CSR_CLIP_HEIGHT: clip_height_ff <= csr_wdata[ClipHW-1:0];
            default: begin
            end
         endcase
      end
   end

   // captured render fields
   logic [1:0] third_ff;
   logic [2:0] row_ff;
   logic [2:0] line_ff;
   logic [4:0] col_ff;
   logic       bits_ok_ff;
   logic [7:0] bits_ff;

   // interleaved bitmap address and attribute address
   logic [AddrW-1:0] bits_addr;
   logic [AddrW-1:0] attr_rd_addr;
   logic             bits_ok;
   logic             attr_ok;

   assign bits_addr    = {in_third, in_line, in_row, in_col};
   assign attr_rd_addr = {AttrBaseTop, 1'b0, third_ff, row_ff, col_ff};
   assign bits_ok      = (bits_addr < ScreenLimit);
   assign attr_ok      = (third_ff != ThirdBeyond);

   // single-port screen image
   logic [7:0]       mem [0:ScreenBytes-1];
   logic [7:0]       rd_data_ff;
   logic             mem_wr;
   logic             mem_rd;
   logic [AddrW-1:0] mem_addr;

   assign mem_wr   = cmd.write_byte && (in_addr < ScreenLimit);
   assign mem_rd   = (cmd.start_render && bits_ok) || (cmd.read_attr && attr_ok);
   assign mem_addr = cmd.read_attr ? attr_rd_addr : (cmd.start_render ? bits_addr : in_addr);

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_addr] <= in_value;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_render) begin
         third_ff   <= in_third;
         row_ff     <= in_row;
         line_ff    <= in_line;
         col_ff     <= in_col;
         bits_ok_ff <= bits_ok;
      end
      if (cmd.read_attr) begin
         // out-of-image bitmap byte reads as zero
         bits_ff <= bits_ok_ff ? rd_data_ff : 8'd0;
      end
   end

   // colour decode
   logic [7:0]      attr;
   logic [3:0]      ink;
   logic [3:0]      paper;
   logic [ColW-1:0] colours;

   assign attr  = attr_ok ? rd_data_ff : 8'd0;
   assign ink   = {attr[BrightBit], attr[2:0]};
   assign paper = {attr[BrightBit], attr[5:3]};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         colours[4*i +: 4] = bits_ff[i] ? ink : paper;
      end
   end

   // coordinates and clip mask
   logic [PixXW-1:0]  px;
   logic [PixYW-1:0]  py;
   logic [MaskW-1:0]  mask;
   logic              y_in;

   assign px   = PixXW'(x_offset_ff) + PixXW'({col_ff, 3'b000});
   assign py   = PixYW'(y_offset_ff) + PixYW'({third_ff, row_ff, line_ff});
   assign y_in = (py < clip_height_ff);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask[7-i] = y_in && ((11'(px) + 11'(i)) < 11'(clip_width_ff));
      end
   end

   // output register
   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {5'd0, mask, colours, py, px};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
